// ----- rtl/lcwd_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the lcw decompressor
package lcwd_pkg;

   localparam int LCWD_HISTORY_DEPTH = 65536;

   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_BYTE  = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   localparam logic [7:0] CMD_END      = 8'h80;
   localparam logic [7:0] CMD_FILL     = 8'hFE;
   localparam logic [7:0] CMD_ABS_LONG = 8'hFF;

   localparam logic [16:0] OUT_LENGTH_RESET = 17'h10000;

   typedef enum logic [3:0] {
      PH_DONE     = 4'd0,
      PH_CMD      = 4'd1,
      PH_REL_LO   = 4'd2,
      PH_FILL_SZ0 = 4'd3,
      PH_FILL_SZ1 = 4'd4,
      PH_FILL_VAL = 4'd5,
      PH_ABS_SZ0  = 4'd6,
      PH_ABS_SZ1  = 4'd7,
      PH_ABS_OF0  = 4'd8,
      PH_ABS_OF1  = 4'd9,
      PH_LITERAL  = 4'd10,
      PH_RUN      = 4'd11
   } lcwd_phase_type;

   typedef enum logic [1:0] {
      OP_REL  = 2'd0,
      OP_ABS  = 2'd1,
      OP_FILL = 2'd2
   } lcwd_op_type;

   // one decoded step handed from the parser to the history stage
   typedef struct packed {
      logic        res;
      logic        use_mem;
      logic [7:0]  val;
      logic [15:0] pos;
      logic        kind;
      logic        last;
   } lcwd_issue_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [15:0] out_pos;
      logic        kind;
      logic        is_last;
   } lcwd_rsp_type;

endpackage

// ----- rtl/lcwd_req_if.sv -----
`timescale 1ns / 1ps
// request channel of the lcw decompressor
interface lcwd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] in_byte;

   modport source (output valid, output func, output in_byte, input ready);
   modport sink (input valid, input func, input in_byte, output ready);
endinterface

// ----- rtl/lcwd_rsp_if.sv -----
`timescale 1ns / 1ps
// response channel of the lcw decompressor
interface lcwd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [15:0] out_pos;
   logic        kind;
   logic        is_last;

   modport source (output valid, output out_byte, output out_pos, output kind,
                   output is_last, input ready);
   modport sink (input valid, input out_byte, input out_pos, input kind,
                 input is_last, output ready);
endinterface

// ----- rtl/lcwd_ram.sv -----
`timescale 1ns / 1ps
// generic single-port-write ram with registered read
module lcwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lcwd_parser.sv -----
`timescale 1ns / 1ps
// command parser: frame state, run counters and history read address
module lcwd_parser #(
   parameter int HISTORY_DEPTH = lcwd_pkg::LCWD_HISTORY_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [1:0]                       func,
   input  logic [7:0]                       in_byte,
   input  logic                             csr_wr_en,
   input  logic [16:0]                      csr_wr_data,
   output lcwd_pkg::lcwd_issue_type         issue,
   output logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr
);
   import lcwd_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam logic [16:0] DEPTH_W = 17'(HISTORY_DEPTH);

   lcwd_phase_type phase_ff, phase_in;
   lcwd_op_type    op_ff, op_in;
   logic [15:0]    rem_ff, rem_in;
   logic [15:0]    src_ff, src_in;
   logic [11:0]    back_ff, back_in;
   logic [7:0]     fill_ff, fill_in;
   logic [16:0]    wp_ff, wp_in;
   logic [16:0]    frame_len_ff, frame_len_in;
   logic [16:0]    out_length_ff;

   logic [16:0]    len_clamped;
   logic [16:0]    rel_addr;
   logic           rel_ok;
   logic           abs_ok;
   logic [11:0]    back_new;
   logic [15:0]    rem_dec;
   logic           do_emit;
   logic [7:0]     emit_val;
   logic           use_mem;
   logic [16:0]    rd_addr_full;

   function automatic logic [15:0] clamp_run(input logic [16:0] size,
                                             input logic [16:0] frame_len,
                                             input logic [16:0] wr_pos);
      logic [16:0] left;
      left = frame_len - wr_pos;
      return (size < left) ? size[15:0] : left[15:0];
   endfunction

   assign len_clamped = (out_length_ff > DEPTH_W) ? DEPTH_W : out_length_ff;
   assign rel_addr    = wp_ff - {5'b0, back_ff};
   assign rel_ok      = (back_ff != 12'd0) && ({5'b0, back_ff} <= wp_ff);
   assign abs_ok      = ({1'b0, src_ff} < wp_ff) && ({1'b0, src_ff} < DEPTH_W);
   assign back_new    = back_ff | {4'h0, in_byte};
   assign rem_dec     = rem_ff - 16'd1;
   assign rd_addr     = rd_addr_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_length_ff <= OUT_LENGTH_RESET;
      end else if (csr_wr_en) begin
         out_length_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DONE;
         op_ff        <= OP_REL;
         rem_ff       <= '0;
         src_ff       <= '0;
         back_ff      <= '0;
         fill_ff      <= '0;
         wp_ff        <= '0;
         frame_len_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         op_ff        <= op_in;
         rem_ff       <= rem_in;
         src_ff       <= src_in;
         back_ff      <= back_in;
         fill_ff      <= fill_in;
         wp_ff        <= wp_in;
         frame_len_ff <= frame_len_in;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      op_in        = op_ff;
      rem_in       = rem_ff;
      src_in       = src_ff;
      back_in      = back_ff;
      fill_in      = fill_ff;
      wp_in        = wp_ff;
      frame_len_in = frame_len_ff;
      issue        = '0;
      do_emit      = 1'b0;
      emit_val     = 8'h00;
      use_mem      = 1'b0;
      rd_addr_full = '0;

      if (accept) begin
         case (func)
            FUNC_START: begin
               frame_len_in = len_clamped;
               wp_in        = '0;
               rem_in       = '0;
               op_in        = OP_REL;
               src_in       = '0;
               back_in      = '0;
               fill_in      = '0;
               phase_in     = (len_clamped == 17'd0) ? PH_DONE : PH_CMD;
            end
            FUNC_BYTE: begin
               case (phase_ff)
                  PH_CMD: begin
                     if (in_byte == CMD_END) begin
                        issue.res  = 1'b1;
                        issue.kind = 1'b1;
                        issue.last = 1'b1;
                        issue.pos  = wp_ff[15:0];
                        phase_in   = PH_DONE;
                     end else if (!in_byte[7]) begin
                        rem_in   = clamp_run({14'b0, in_byte[6:4]} + 17'd3,
                                             frame_len_ff, wp_ff);
                        back_in  = {in_byte[3:0], 8'h00};
                        phase_in = PH_REL_LO;
                     end else if (in_byte == CMD_FILL) begin
                        phase_in = PH_FILL_SZ0;
                     end else if (in_byte == CMD_ABS_LONG) begin
                        phase_in = PH_ABS_SZ0;
                     end else if (in_byte[6]) begin
                        rem_in   = clamp_run({11'b0, in_byte[5:0]} + 17'd3,
                                             frame_len_ff, wp_ff);
                        phase_in = PH_ABS_OF0;
                     end else begin
                        rem_in   = clamp_run({11'b0, in_byte[5:0]}, frame_len_ff, wp_ff);
                        phase_in = (in_byte[5:0] == 6'd0 || wp_ff == frame_len_ff)
                                   ? PH_CMD : PH_LITERAL;
                     end
                  end
                  PH_REL_LO: begin
                     back_in = back_new;
                     op_in   = OP_REL;
                     if ({5'b0, back_new} > wp_ff) begin
                        rem_in   = '0;
                        phase_in = PH_CMD;
                     end else begin
                        phase_in = (rem_ff == 16'd0) ? PH_CMD : PH_RUN;
                     end
                  end
                  PH_FILL_SZ0: begin
                     rem_in   = {8'h00, in_byte};
                     phase_in = PH_FILL_SZ1;
                  end
                  PH_FILL_SZ1: begin
                     rem_in   = clamp_run({1'b0, in_byte, rem_ff[7:0]}, frame_len_ff, wp_ff);
                     phase_in = PH_FILL_VAL;
                  end
                  PH_FILL_VAL: begin
                     fill_in  = in_byte;
                     op_in    = OP_FILL;
                     phase_in = (rem_ff == 16'd0) ? PH_CMD : PH_RUN;
                  end
                  PH_ABS_SZ0: begin
                     rem_in   = {8'h00, in_byte};
                     phase_in = PH_ABS_SZ1;
                  end
                  PH_ABS_SZ1: begin
                     rem_in   = clamp_run({1'b0, in_byte, rem_ff[7:0]}, frame_len_ff, wp_ff);
                     phase_in = PH_ABS_OF0;
                  end
                  PH_ABS_OF0: begin
                     src_in   = {8'h00, in_byte};
                     phase_in = PH_ABS_OF1;
                  end
                  PH_ABS_OF1: begin
                     src_in   = {in_byte, src_ff[7:0]};
                     op_in    = OP_ABS;
                     phase_in = (rem_ff == 16'd0) ? PH_CMD : PH_RUN;
                  end
                  PH_LITERAL: begin
                     rem_in   = rem_dec;
                     phase_in = (rem_dec == 16'd0) ? PH_CMD : PH_LITERAL;
                     do_emit  = 1'b1;
                     emit_val = in_byte;
                  end
                  default: begin
                  end
               endcase
            end
            FUNC_TICK: begin
               if (phase_ff == PH_RUN && rem_ff != 16'd0) begin
                  rem_in   = rem_dec;
                  phase_in = (rem_dec == 16'd0) ? PH_CMD : PH_RUN;
                  do_emit  = 1'b1;
                  case (op_ff)
                     OP_FILL: begin
                        emit_val = fill_ff;
                     end
                     OP_ABS: begin
                        if (abs_ok) begin
                           use_mem      = 1'b1;
                           rd_addr_full = {1'b0, src_ff};
                        end
                        src_in = src_ff + 16'd1;
                     end
                     OP_REL: begin
                        // distance zero or before frame start reads as zero
                        if (rel_ok) begin
                           use_mem      = 1'b1;
                           rd_addr_full = rel_addr;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end

      if (do_emit) begin
         issue.res     = 1'b1;
         issue.use_mem = use_mem;
         issue.val     = emit_val;
         issue.pos     = wp_ff[15:0];
         wp_in         = wp_ff + 17'd1;
         issue.last    = (wp_in >= frame_len_ff);
         if (issue.last) begin
            phase_in = PH_DONE;
         end
      end
   end

endmodule

// ----- rtl/lcwd_out_queue.sv -----
`timescale 1ns / 1ps
// two-entry response queue driving the response channel
module lcwd_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lcwd_pkg::lcwd_rsp_type push_data,
   output logic                   full,
   lcwd_rsp_if.source             rsp_if
);
   import lcwd_pkg::*;

   lcwd_rsp_type entry_ff [2];
   lcwd_rsp_type head;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop  = rsp_if.valid && rsp_if.ready;
   assign full = (count_ff == 2'd2);
   assign head = entry_ff[rd_ptr_ff];

   assign rsp_if.valid    = (count_ff != 2'd0);
   assign rsp_if.out_byte = head.out_byte;
   assign rsp_if.out_pos  = head.out_pos;
   assign rsp_if.kind     = head.kind;
   assign rsp_if.is_last  = head.is_last;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/lcw_decompressor_unit.sv -----
`timescale 1ns / 1ps
// lcw decompressor top level: parser, history ram and response queue
//
// req_if carries one item per transaction: func 0 starts a frame (length taken
// from the csr register), func 1 pushes a compressed byte, func 2 ticks out one
// byte of a pending move or fill. rsp_if returns decoded bytes with their frame
// position, or an end marker. csr_wr_en/csr_wr_data set the frame length; write
// it only while the block is idle.
// One item is accepted per cycle while req_if.ready is high. A result passes
// through the history stage register and the response queue. The history ram
// read is issued at acceptance and returns in the next cycle; a history read
// of the byte still in flight is forwarded around the ram.
// Reset empties the pipeline and the queue, leaves no frame open and sets the
// frame length to 65536. History contents are not cleared.
// If rsp_if stalls, the two-entry queue absorbs results; once it is full and
// another result waits in the history stage, req_if.ready drops until a
// response transaction frees a slot.
module lcw_decompressor_unit #(
   parameter int HISTORY_DEPTH = lcwd_pkg::LCWD_HISTORY_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   lcwd_req_if.sink    req_if,
   lcwd_rsp_if.source  rsp_if,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data
);
   import lcwd_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);

   lcwd_issue_type issue;
   lcwd_issue_type s2_issue_ff;
   lcwd_rsp_type   push_data;
   logic [AW-1:0]  rd_addr;
   logic [7:0]     ram_rdata;
   logic           enable;
   logic           accept;
   logic           q_full;
   logic           s2_valid_ff, s2_valid_in;
   logic           s2_fwd_ff, s2_fwd_in;
   logic [7:0]     last_byte_ff;
   logic [7:0]     s2_byte;
   logic           ram_we;
   logic           ram_re;

   assign enable       = !(s2_valid_ff && q_full);
   assign req_if.ready = enable;
   assign accept       = req_if.valid && enable;

   lcwd_parser #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (req_if.func),
      .in_byte     (req_if.in_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .issue       (issue),
      .rd_addr     (rd_addr)
   );

   // read of the entry being written by the step ahead takes its byte directly
   assign s2_fwd_in   = issue.use_mem && s2_valid_ff && !s2_issue_ff.kind &&
                        (s2_issue_ff.pos[AW-1:0] == rd_addr);
   assign s2_valid_in = accept && issue.res;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_issue_ff <= issue;
         s2_fwd_ff   <= s2_fwd_in;
      end
      if (ram_we) begin
         last_byte_ff <= s2_byte;
      end
   end

   assign s2_byte = s2_issue_ff.use_mem ? (s2_fwd_ff ? last_byte_ff : ram_rdata)
                                        : s2_issue_ff.val;
   assign ram_we  = enable && s2_valid_ff && !s2_issue_ff.kind;
   assign ram_re  = accept && issue.use_mem;

   lcwd_ram #(
      .WIDTH(8),
      .DEPTH(HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s2_issue_ff.pos[AW-1:0]),
      .wr_data (s2_byte),
      .rd_en   (ram_re),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   assign push_data.out_byte = s2_byte;
   assign push_data.out_pos  = s2_issue_ff.pos;
   assign push_data.kind     = s2_issue_ff.kind;
   assign push_data.is_last  = s2_issue_ff.last;

   lcwd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (enable && s2_valid_ff),
      .push_data (push_data),
      .full      (q_full),
      .rsp_if    (rsp_if)
   );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the lcw decompressor unit with a built-in decode predictor
module tb;
   import lcwd_pkg::*;

   localparam logic       KIND_DATA     = 1'b0;
   localparam logic       KIND_END      = 1'b1;
   localparam logic [1:0] FUNC_NONE     = 2'd3;
   localparam logic       TAG_REL       = 1'b0;
   localparam logic [1:0] TAG_LITERAL   = 2'b10;
   localparam logic [1:0] TAG_ABS_SHORT = 2'b11;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int STREAM_ITEMS  = 480;
   localparam int PLAN_ROWS     = 30;

   localparam lcwd_rsp_type NO_RSP = '0;

   typedef struct packed {
      logic         csr;
      logic [16:0]  length;
      logic [1:0]   func;
      logic [7:0]   in_byte;
      logic         known;
      lcwd_rsp_type rsp;
   } plan_row_type;

   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{1'b1, 17'd3, FUNC_START, 8'h00, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, CMD_END, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_TICK, 8'h00, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_NONE, 8'hFF, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_START, 8'h00, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, {TAG_LITERAL, 6'd1}, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, 8'hFF, 1'b1, '{8'hFF, 16'd0, KIND_DATA, 1'b0}},
      '{1'b0, 17'd0, FUNC_BYTE, {TAG_REL, 3'd0, 4'd0}, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, 8'h00, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, 8'h12, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_TICK, 8'h00, 1'b1, '{8'h00, 16'd1, KIND_DATA, 1'b0}},
      '{1'b0, 17'd0, FUNC_TICK, 8'hFF, 1'b1, '{8'h00, 16'd2, KIND_DATA, 1'b1}},
      '{1'b0, 17'd0, FUNC_TICK, 8'h00, 1'b0, NO_RSP},
      '{1'b1, 17'd0, FUNC_START, 8'h00, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_START, 8'h00, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, {TAG_LITERAL, 6'd1}, 1'b0, NO_RSP},
      '{1'b1, 17'h1FFFF, FUNC_START, 8'h00, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_START, 8'h00, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, {TAG_REL, 3'd0, 4'hF}, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, 8'hFF, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, CMD_FILL, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, 8'h00, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, 8'h00, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, 8'h99, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, {TAG_ABS_SHORT, 6'd0}, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, 8'h34, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, 8'h12, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_TICK, 8'h00, 1'b1, '{8'h00, 16'd0, KIND_DATA, 1'b0}},
      '{1'b0, 17'd0, FUNC_START, 8'h00, 1'b0, NO_RSP},
      '{1'b0, 17'd0, FUNC_BYTE, CMD_END, 1'b1, '{8'h00, 16'd0, KIND_END, 1'b1}}
   };

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [16:0] csr_wr_data;

   lcwd_req_if req_ch ();
   lcwd_rsp_if rsp_ch ();

   lcw_decompressor_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // decoder state mirrored by the predictor
   logic [7:0]     hist_mem [LCWD_HISTORY_DEPTH];
   int             wr_pos      = 0;
   int             run_left    = 0;
   int             frame_bytes = 0;
   logic [16:0]    len_reg     = OUT_LENGTH_RESET;
   lcwd_phase_type ph          = PH_DONE;
   lcwd_op_type    op          = OP_REL;
   logic [15:0]    src_pos     = '0;
   logic [11:0]    back_dist   = '0;
   logic [7:0]     fill_byte   = '0;

   lcwd_rsp_type   expected_q [$];
   int             mismatches   = 0;
   int             stream_items = 0;
   int             idle_cycles  = 0;
   bit             steady       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int clip_run(int size);
      return (size < frame_bytes - wr_pos) ? size : frame_bytes - wr_pos;
   endfunction

   function automatic lcwd_rsp_type store_byte(logic [7:0] v);
      lcwd_rsp_type r;
      hist_mem[wr_pos] = v;
      r.out_byte = v;
      r.out_pos  = wr_pos[15:0];
      r.kind     = KIND_DATA;
      wr_pos++;
      r.is_last  = (wr_pos >= frame_bytes);
      if (r.is_last) ph = PH_DONE;
      return r;
   endfunction

   // advances the decoder by one transaction, returns 1 when it yields a result
   function automatic bit decode_step(input logic [1:0] f, input logic [7:0] b,
                                      output lcwd_rsp_type r);
      logic [7:0] v;
      r = '0;
      if (f == FUNC_START) begin
         frame_bytes = (len_reg > LCWD_HISTORY_DEPTH) ? LCWD_HISTORY_DEPTH : int'(len_reg);
         wr_pos    = 0;
         run_left  = 0;
         op        = OP_REL;
         src_pos   = '0;
         back_dist = '0;
         fill_byte = '0;
         ph = (frame_bytes == 0) ? PH_DONE : PH_CMD;
         return 1'b0;
      end
      if (f == FUNC_TICK) begin
         if (ph != PH_RUN || run_left == 0) return 1'b0;
         case (op)
            OP_FILL: v = fill_byte;
            OP_ABS: begin
               v = (src_pos < wr_pos) ? hist_mem[src_pos] : 8'h00;
               src_pos++;
            end
            default: v = (back_dist == 0 || back_dist > wr_pos) ? 8'h00
                                                                : hist_mem[wr_pos - back_dist];
         endcase
         run_left--;
         if (run_left == 0) ph = PH_CMD;
         r = store_byte(v);
         return 1'b1;
      end
      if (f != FUNC_BYTE) return 1'b0;
      case (ph)
         PH_CMD: begin
            if (b == CMD_END) begin
               r  = '{8'h00, wr_pos[15:0], KIND_END, 1'b1};
               ph = PH_DONE;
               return 1'b1;
            end
            if (b[7] == TAG_REL) begin
               run_left  = clip_run(int'(b[6:4]) + 3);
               back_dist = {b[3:0], 8'h00};
               ph = PH_REL_LO;
            end else if (b == CMD_FILL) begin
               ph = PH_FILL_SZ0;
            end else if (b == CMD_ABS_LONG) begin
               ph = PH_ABS_SZ0;
            end else if (b[7:6] == TAG_ABS_SHORT) begin
               run_left = clip_run(int'(b[5:0]) + 3);
               ph = PH_ABS_OF0;
            end else begin
               run_left = clip_run(int'(b[5:0]));
               ph = (run_left == 0) ? PH_CMD : PH_LITERAL;
            end
         end
         PH_REL_LO: begin
            back_dist[7:0] = b;
            op = OP_REL;
            // reaching before the frame start drops the whole run
            if (back_dist > wr_pos) run_left = 0;
            ph = (run_left == 0) ? PH_CMD : PH_RUN;
         end
         PH_FILL_SZ0: begin
            run_left = int'(b);
            ph = PH_FILL_SZ1;
         end
         PH_FILL_SZ1: begin
            run_left = clip_run(run_left + (int'(b) << 8));
            ph = PH_FILL_VAL;
         end
         PH_FILL_VAL: begin
            fill_byte = b;
            op = OP_FILL;
            ph = (run_left == 0) ? PH_CMD : PH_RUN;
         end
         PH_ABS_SZ0: begin
            run_left = int'(b);
            ph = PH_ABS_SZ1;
         end
         PH_ABS_SZ1: begin
            run_left = clip_run(run_left + (int'(b) << 8));
            ph = PH_ABS_OF0;
         end
         PH_ABS_OF0: begin
            src_pos = {8'h00, b};
            ph = PH_ABS_OF1;
         end
         PH_ABS_OF1: begin
            src_pos[15:8] = b;
            op = OP_ABS;
            ph = (run_left == 0) ? PH_CMD : PH_RUN;
         end
         PH_LITERAL: begin
            run_left--;
            if (run_left == 0) ph = PH_CMD;
            r = store_byte(b);
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task automatic send_item(input logic [1:0] f, input logic [7:0] b, input bit counts = 1'b1,
                            input bit known = 1'b0, input lcwd_rsp_type known_rsp = '0);
      int           gap;
      bit           got;
      lcwd_rsp_type r;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.func    <= f;
      req_ch.in_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      got = decode_step(f, b, r);
      if (known) expected_q.push_back(known_rsp);
      else if (got) expected_q.push_back(r);
      if (counts) stream_items++;
   endtask

   // frame length changes only once the pipeline has drained
   task automatic write_length(input logic [16:0] v);
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      len_reg = v;
   endtask

   // ticks out a pending run, with the odd ignored byte mixed in
   task automatic run_out();
      while (ph == PH_RUN) begin
         if ($urandom_range(0, 15) == 0) send_item(FUNC_BYTE, 8'($urandom), 1'b0);
         send_item(FUNC_TICK, 8'($urandom));
      end
   endtask

   task automatic random_frame();
      int          cmds;
      int          pick;
      int          n;
      logic [15:0] span;
      logic [15:0] origin;
      logic [11:0] reach;
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) begin
         case ($urandom_range(0, 9))
            0:       write_length(17'd1);
            1:       write_length(OUT_LENGTH_RESET);
            2:       write_length(17'd0);
            3:       write_length(17'($urandom_range(65537, 131071)));
            4, 5:    write_length(17'($urandom_range(1, 8)));
            default: write_length(17'($urandom_range(1, 64)));
         endcase
      end
      send_item(FUNC_START, 8'($urandom));
      cmds = $urandom_range(1, 12);
      while (cmds > 0 && ph != PH_DONE) begin
         cmds--;
         pick = $urandom_range(0, 19);
         span = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
         if (frame_bytes > 256) span[15:8] = 8'h00;
         origin = ($urandom_range(0, 5) == 0 || wr_pos == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, wr_pos - 1));
         reach = ($urandom_range(0, 5) == 0)
                 ? 12'($urandom)
                 : 12'($urandom_range(0, (wr_pos < 4095) ? wr_pos : 4095));
         if (pick < 5) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
            send_item(FUNC_BYTE, {TAG_LITERAL, 6'(n)});
            while (ph == PH_LITERAL) send_item(FUNC_BYTE, 8'($urandom));
         end else if (pick < 9) begin
            send_item(FUNC_BYTE, {TAG_REL, 3'($urandom), reach[11:8]});
            send_item(FUNC_BYTE, reach[7:0]);
         end else if (pick < 11) begin
            send_item(FUNC_BYTE, CMD_FILL);
            send_item(FUNC_BYTE, span[7:0]);
            send_item(FUNC_BYTE, span[15:8]);
            send_item(FUNC_BYTE, 8'($urandom));
         end else if (pick < 13) begin
            send_item(FUNC_BYTE, CMD_ABS_LONG);
            send_item(FUNC_BYTE, span[7:0]);
            send_item(FUNC_BYTE, span[15:8]);
            send_item(FUNC_BYTE, origin[7:0]);
            send_item(FUNC_BYTE, origin[15:8]);
         end else if (pick < 16) begin
            // sizes 62 and 63 would alias the long fill and long move codes
            send_item(FUNC_BYTE, {TAG_ABS_SHORT, 6'($urandom_range(0, 61))});
            send_item(FUNC_BYTE, origin[7:0]);
            send_item(FUNC_BYTE, origin[15:8]);
         end else if (pick == 16) begin
            send_item(FUNC_BYTE, CMD_END);
         end else begin
            send_item(2'($urandom), 8'($urandom), 1'b0);
         end
         run_out();
      end
   endtask

   initial begin
      int row;
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.func    <= FUNC_START;
      req_ch.in_byte <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < PLAN_ROWS; row++) begin
         if (DIRECTED_PLAN[row].csr)
            write_length(DIRECTED_PLAN[row].length);
         else
            send_item(DIRECTED_PLAN[row].func, DIRECTED_PLAN[row].in_byte, 1'b0,
                      DIRECTED_PLAN[row].known, DIRECTED_PLAN[row].rsp);
      end

      stream_items = 0;
      while (stream_items < STREAM_ITEMS) random_frame();

      // a short frame: a fill of 47 bytes closed by a clamped literal
      steady = 1'b0;
      write_length(17'd48);
      send_item(FUNC_START, 8'h00);
      send_item(FUNC_BYTE, CMD_FILL);
      send_item(FUNC_BYTE, 8'h2F);
      send_item(FUNC_BYTE, 8'h00);
      send_item(FUNC_BYTE, 8'h5A);
      run_out();
      send_item(FUNC_BYTE, {TAG_LITERAL, 6'd2});
      send_item(FUNC_BYTE, 8'hA5);

      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[lcw_decompressor_unit] OK");
      else
         $display("[lcw_decompressor_unit] ERROR");
      $finish;
   end

   initial begin : rsp_side
      int           stall;
      lcwd_rsp_type seen;
      lcwd_rsp_type want;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         seen = '{rsp_ch.out_byte, rsp_ch.out_pos, rsp_ch.kind, rsp_ch.is_last};
         if (expected_q.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected rsp transaction: byte %h pos %0d kind %0d last %0d",
                        seen.out_byte, seen.out_pos, seen.kind, seen.is_last);
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            if (seen.out_byte !== want.out_byte || seen.out_pos !== want.out_pos ||
                seen.kind !== want.kind || seen.is_last !== want.is_last) begin
               if (mismatches < 10)
                  $display({"rsp mismatch: expected byte %h pos %0d kind %0d last %0d, ",
                            "got %h %0d %0d %0d"},
                           want.out_byte, want.out_pos, want.kind, want.is_last,
                           seen.out_byte, seen.out_pos, seen.kind, seen.is_last);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[lcw_decompressor_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ----- filelist.f -----
rtl/lcwd_pkg.sv
rtl/lcwd_req_if.sv
rtl/lcwd_rsp_if.sv
rtl/lcwd_ram.sv
rtl/lcwd_parser.sv
rtl/lcwd_out_queue.sv
rtl/lcw_decompressor_unit.sv
tb/tb.sv
